>>> hw/rtl/cer_pkg.sv
// shared constants for the calorimeter energy resolution pipeline
// used by cer_div, cer_sqrt and calorimeter_energy_resolution
package cer_pkg;

  localparam int COEF_W     = 24;
  localparam int ENERGY_W   = 32;
  localparam int ETA_W      = 16;
  localparam int RES_W      = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int PROD_W     = 2 * COEF_W;
  localparam int VAR_W      = 64;
  localparam int DIV_NUM_W  = 72;

  localparam logic [ETA_W:0] ETA_ENDCAP_LOW  = 17'd6058;
  localparam logic [ETA_W:0] ETA_ENDCAP_HIGH = 17'd12288;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BARREL_STOCHASTIC = 3'd0,
    REG_BARREL_NOISE      = 3'd1,
    REG_BARREL_CONSTANT   = 3'd2,
    REG_ENDCAP_STOCHASTIC = 3'd3,
    REG_ENDCAP_NOISE      = 3'd4,
    REG_ENDCAP_CONSTANT   = 3'd5
  } cfg_reg_t;

endpackage

>>> hw/rtl/cer_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on cer_pkg for the divisor width
module cer_div #(
  parameter int NUM_W = 72,
  parameter int Q_W   = 64
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [NUM_W-1:0]             num,
  input  logic [cer_pkg::ENERGY_W-1:0] den,
  output logic [Q_W-1:0]               quo,
  output logic                         ovf
);
  import cer_pkg::*;

  logic [ENERGY_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0]    num_r [NUM_W];
  logic [ENERGY_W-1:0] den_r [NUM_W];
  logic [Q_W-1:0]      q_r   [NUM_W];
  logic                ovf_r [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [ENERGY_W-1:0] rem_in;
    logic [NUM_W-1:0]    num_in;
    logic [ENERGY_W-1:0] den_in;
    logic [Q_W-1:0]      q_in;
    logic                ovf_in;
    logic [ENERGY_W:0]   trial;
    logic                ge;
    logic [ENERGY_W:0]   diff;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign den_in = den;
      assign q_in   = '0;
      assign ovf_in = 1'b0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign num_in = num_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
      assign ovf_in = ovf_r[i-1];
    end

    always_comb begin
      trial = {rem_in, num_in[NUM_W-1]};
      ge    = (trial >= {1'b0, den_in});
      diff  = trial - {1'b0, den_in};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[ENERGY_W-1:0] : trial[ENERGY_W-1:0];
        num_r[i] <= {num_in[NUM_W-2:0], 1'b0};
        den_r[i] <= den_in;
        q_r[i]   <= {q_in[Q_W-2:0], ge};
        ovf_r[i] <= ovf_in | q_in[Q_W-1];
      end
    end
  end

  assign quo = q_r[NUM_W-1];
  assign ovf = ovf_r[NUM_W-1];

endmodule

>>> hw/rtl/cer_sqrt.sv
// pipelined integer square root of a 64-bit value, one root bit per stage
// depends on cer_pkg for widths
module cer_sqrt (
  input  logic                      clk,
  input  logic                      en,
  input  logic [cer_pkg::VAR_W-1:0] val,
  output logic [cer_pkg::RES_W-1:0] root
);
  import cer_pkg::*;

  localparam int REM_W = RES_W + 2;

  logic [REM_W-1:0] rem_r  [RES_W];
  logic [RES_W-1:0] root_r [RES_W];
  logic [VAR_W-1:0] val_r  [RES_W];

  for (genvar i = 0; i < RES_W; i++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [RES_W-1:0] root_in;
    logic [VAR_W-1:0] val_in;
    logic [REM_W:0]   cur;
    logic [REM_W:0]   trial;
    logic             ge;
    logic [REM_W:0]   diff;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = val;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign val_in  = val_r[i-1];
    end

    always_comb begin
      cur   = {rem_in[REM_W-2:0], val_in[VAR_W-1:VAR_W-2]};
      trial = {1'b0, root_in, 2'b01};
      ge    = (cur >= trial);
      diff  = cur - trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        root_r[i] <= {root_in[RES_W-2:0], ge};
        val_r[i]  <= {val_in[VAR_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[RES_W-1];

endmodule

>>> hw/rtl/calorimeter_energy_resolution.sv
// calorimeter energy resolution, stochastic / noise / constant form
// accepts one transaction per cycle unless a result waits and out_tready is low
// the datapath runs through the 72-stage dividers and the 32-stage square root, one bit per stage
// the whole pipeline holds while a result waits and out_tready is low
// synchronous active-low reset clears valid bits and coefficients to zero
module calorimeter_energy_resolution (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cer_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cer_pkg::COEF_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [47:0]                    in_tdata,  // cluster_energy, pseudorapidity
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata, // relative_resolution
  output logic                           out_tuser  // zero_energy_error
);
  import cer_pkg::*;

  localparam int DIV_LAT  = DIV_NUM_W;
  localparam int SQRT_LAT = RES_W;

  logic en;
  logic [COEF_W-1:0] coef_r [6];

  // front stage
  logic [ENERGY_W-1:0] e_in;
  logic [ETA_W-1:0]    eta_in;
  logic [ETA_W:0]      aeta;
  logic                endcap;
  logic                v0_r, z0_r;
  logic [ENERGY_W-1:0] e0_r;
  logic [COEF_W-1:0]   s0_r, n0_r, c0_r;
  // products
  logic                v1_r, z1_r;
  logic [ENERGY_W-1:0] e1_r;
  logic [PROD_W-1:0]   sq1_r, c21_r;
  logic [COEF_W-1:0]   n1_r;
  // divider side line
  logic                vd_r [DIV_LAT];
  logic                zd_r [DIV_LAT];
  logic [VAR_W-1:0]    t3d_r [DIV_LAT];
  logic [VAR_W-1:0]    q1;
  logic                ovf1;
  logic [RES_W-1:0]    q2;
  logic                ovf2;
  // terms and sums
  logic                v2_r, z2_r, v3_r, z3_r, v4_r, z4_r;
  logic [VAR_W-1:0]    t1_r, t2_r, t3_r, a3_r, t33_r, var4_r;
  logic [VAR_W:0]      sum3, sum4;
  // sqrt side line
  logic                vs_r [SQRT_LAT];
  logic                zs_r [SQRT_LAT];
  logic [RES_W-1:0]    root;
  logic                out_valid_r, out_zero_r;
  logic [RES_W-1:0]    out_res_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BARREL_STOCHASTIC: coef_r[0] <= cfg_wdata;
        REG_BARREL_NOISE:      coef_r[1] <= cfg_wdata;
        REG_BARREL_CONSTANT:   coef_r[2] <= cfg_wdata;
        REG_ENDCAP_STOCHASTIC: coef_r[3] <= cfg_wdata;
        REG_ENDCAP_NOISE:      coef_r[4] <= cfg_wdata;
        REG_ENDCAP_CONSTANT:   coef_r[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    e_in   = in_tdata[ENERGY_W-1:0];
    eta_in = in_tdata[ENERGY_W +: ETA_W];
    aeta   = eta_in[ETA_W-1] ? (-{eta_in[ETA_W-1], eta_in}) : {1'b0, eta_in};
    endcap = (aeta >= ETA_ENDCAP_LOW) && (aeta < ETA_ENDCAP_HIGH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        vd_r[i] <= 1'b0;
      end
      for (int i = 0; i < SQRT_LAT; i++) begin
        vs_r[i] <= 1'b0;
      end
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      vd_r[0] <= v1_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        vd_r[i] <= vd_r[i-1];
      end
      v2_r <= vd_r[DIV_LAT-1];
      v3_r <= v2_r;
      v4_r <= v3_r;
      vs_r[0] <= v4_r;
      for (int i = 1; i < SQRT_LAT; i++) begin
        vs_r[i] <= vs_r[i-1];
      end
      out_valid_r <= vs_r[SQRT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z0_r <= (e_in == '0);
      e0_r <= e_in;
      s0_r <= endcap ? coef_r[3] : coef_r[0];
      n0_r <= endcap ? coef_r[4] : coef_r[1];
      c0_r <= endcap ? coef_r[5] : coef_r[2];

      z1_r  <= z0_r;
      e1_r  <= e0_r;
      sq1_r <= s0_r * s0_r;
      c21_r <= c0_r * c0_r;
      n1_r  <= n0_r;

      zd_r[0]  <= z1_r;
      t3d_r[0] <= {8'b0, c21_r, 8'b0};
      for (int i = 1; i < DIV_LAT; i++) begin
        zd_r[i]  <= zd_r[i-1];
        t3d_r[i] <= t3d_r[i-1];
      end

      z2_r <= zd_r[DIV_LAT-1];
      t1_r <= ovf1 ? '1 : q1;
      t2_r <= ovf2 ? '1 : (q2 * q2);
      t3_r <= t3d_r[DIV_LAT-1];

      z3_r  <= z2_r;
      a3_r  <= sum3[VAR_W] ? '1 : sum3[VAR_W-1:0];
      t33_r <= t3_r;

      z4_r   <= z3_r;
      var4_r <= sum4[VAR_W] ? '1 : sum4[VAR_W-1:0];

      zs_r[0] <= z4_r;
      for (int i = 1; i < SQRT_LAT; i++) begin
        zs_r[i] <= zs_r[i-1];
      end

      out_zero_r <= zs_r[SQRT_LAT-1];
      out_res_r  <= zs_r[SQRT_LAT-1] ? '1 : root;
    end
  end

  assign sum3 = {1'b0, t1_r} + {1'b0, t2_r};
  assign sum4 = {1'b0, a3_r} + {1'b0, t33_r};

  cer_div #(.NUM_W(DIV_NUM_W), .Q_W(VAR_W)) u_div_stoch (
    .clk (clk),
    .en  (en),
    .num ({sq1_r, 24'b0}),
    .den (e1_r),
    .quo (q1),
    .ovf (ovf1)
  );

  cer_div #(.NUM_W(DIV_NUM_W), .Q_W(RES_W)) u_div_noise (
    .clk (clk),
    .en  (en),
    .num ({28'b0, n1_r, 20'b0}),
    .den (e1_r),
    .quo (q2),
    .ovf (ovf2)
  );

  cer_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .val  (var4_r),
    .root (root)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;
  assign out_tuser  = out_zero_r;

endmodule
